FILE: hdl/tfb_pkg.sv
// ----------------------------------------------------------------------------
// tfb_pkg
// Shared constants and types for the telemetry frame builder.
// ----------------------------------------------------------------------------
`default_nettype none

package tfb_pkg;

  localparam int unsigned MAX_WORDS_DEF = 16;

  localparam logic [7:0] HDR_SYNC   = 8'hAA;
  localparam logic [7:0] HDR_SRC    = 8'h05;
  localparam logic [7:0] HDR_DST    = 8'hAF;
  localparam logic [7:0] FUNC_RESET = 8'hF1;

  // byte positions within the bytes sent for one word
  localparam logic [3:0] POS_SYNC = 4'd0;
  localparam logic [3:0] POS_SRC  = 4'd1;
  localparam logic [3:0] POS_DST  = 4'd2;
  localparam logic [3:0] POS_FUNC = 4'd3;
  localparam logic [3:0] POS_LEN  = 4'd4;
  localparam logic [3:0] POS_W0   = 4'd5;
  localparam logic [3:0] POS_W1   = 4'd6;
  localparam logic [3:0] POS_W2   = 4'd7;
  localparam logic [3:0] POS_W3   = 4'd8;
  localparam logic [3:0] POS_SUM  = 4'd9;

  typedef struct packed {
    logic [31:0] word;
    logic [7:0]  func;
    logic [7:0]  len;
    logic        header;
    logic        close;
    logic [7:0]  checksum;
  } item_t;

endpackage

`default_nettype wire

FILE: hdl/tfb_word_stage.sv
// ----------------------------------------------------------------------------
// tfb_word_stage
// Input register: takes a word, tracks the open frame and works out the
// header, length and checksum the word needs.
// ----------------------------------------------------------------------------
`default_nettype none

module tfb_word_stage #(
  parameter int unsigned MAX_WORDS = tfb_pkg::MAX_WORDS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [31:0]   data_word_i,
  input  wire logic [4:0]    frame_words_i,
  input  wire logic [7:0]    func_i,
  input  wire logic          done_i,
  output logic               item_valid_o,
  output tfb_pkg::item_t     item_o
);

  localparam int CntW = $clog2(MAX_WORDS + 1);
  localparam int CmpW = (CntW > 5) ? CntW : 5;

  logic            item_valid_q, item_valid_d;
  tfb_pkg::item_t  item_q, item_d;
  logic            in_frame_q, in_frame_d;
  logic [CntW-1:0] words_left_q, words_left_d;
  logic [7:0]      running_sum_q, running_sum_d;

  logic            accept;
  logic [CmpW-1:0] cnt_ext;
  logic [CntW-1:0] cnt;
  logic [CntW-1:0] words_eff;
  logic [CntW-1:0] words_next;
  logic            first;
  logic            close;
  logic [7:0]      len;
  logic [7:0]      base_sum;
  logic [7:0]      word_sum;

  assign in_stall_o = item_valid_q && !done_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign first      = !in_frame_q;

  always_comb begin
    cnt_ext = CmpW'(frame_words_i);
    if (cnt_ext == '0) begin
      cnt = CntW'(1);
    end else if (cnt_ext > CmpW'(MAX_WORDS)) begin
      cnt = CntW'(MAX_WORDS);
    end else begin
      cnt = CntW'(cnt_ext);
    end
    len        = 8'({cnt, 2'b00});
    words_eff  = first ? cnt : words_left_q;
    words_next = words_eff - CntW'(1);
    close      = (words_next == '0);
    base_sum   = first ? (tfb_pkg::HDR_SYNC + tfb_pkg::HDR_SRC + tfb_pkg::HDR_DST
                          + func_i + len)
                       : running_sum_q;
    word_sum   = base_sum + data_word_i[31:24] + data_word_i[23:16]
                 + data_word_i[15:8] + data_word_i[7:0];
  end

  always_comb begin
    item_valid_d  = item_valid_q;
    in_frame_d    = in_frame_q;
    words_left_d  = words_left_q;
    running_sum_d = running_sum_q;
    if (done_i) begin
      item_valid_d = 1'b0;
    end
    if (accept) begin
      item_valid_d  = 1'b1;
      in_frame_d    = !close;
      words_left_d  = words_next;
      running_sum_d = close ? 8'h00 : word_sum;
    end
  end

  always_comb begin
    item_d          = item_q;
    if (accept) begin
      item_d.word     = data_word_i;
      item_d.func     = func_i;
      item_d.len      = len;
      item_d.header   = first;
      item_d.close    = close;
      item_d.checksum = word_sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q  <= 1'b0;
      in_frame_q    <= 1'b0;
      words_left_q  <= '0;
      running_sum_q <= 8'h00;
    end else begin
      item_valid_q  <= item_valid_d;
      in_frame_q    <= in_frame_d;
      words_left_q  <= words_left_d;
      running_sum_q <= running_sum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_valid_o = item_valid_q;
  assign item_o       = item_q;

endmodule

`default_nettype wire

FILE: hdl/tfb_byte_seq.sv
// ----------------------------------------------------------------------------
// tfb_byte_seq
// Byte sequencer: walks the held word's bytes into the output register,
// one byte each time the output register is empty or its byte is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module tfb_byte_seq (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           item_valid_i,
  input  wire tfb_pkg::item_t item_i,
  output logic                done_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic [7:0]          out_byte_o,
  output logic                out_frame_end_o,
  output logic                out_last_o
);

  logic       out_valid_q, out_valid_d;
  logic [7:0] byte_q, byte_d;
  logic       frame_end_q, frame_end_d;
  logic       last_q, last_d;
  logic [3:0] idx_q, idx_d;

  logic       advance;
  logic       take;
  logic [3:0] pos;
  logic [3:0] pos_final;
  logic       is_final;
  logic [7:0] sel_byte;

  assign advance   = !out_valid_q || !out_stall_i;
  assign take      = item_valid_i && advance;
  assign pos       = item_i.header ? idx_q : idx_q + tfb_pkg::POS_W0;
  assign pos_final = item_i.close ? tfb_pkg::POS_SUM : tfb_pkg::POS_W3;
  assign is_final  = (pos == pos_final);
  assign done_o    = take && is_final;

  always_comb begin
    unique case (pos)
      tfb_pkg::POS_SYNC: sel_byte = tfb_pkg::HDR_SYNC;
      tfb_pkg::POS_SRC:  sel_byte = tfb_pkg::HDR_SRC;
      tfb_pkg::POS_DST:  sel_byte = tfb_pkg::HDR_DST;
      tfb_pkg::POS_FUNC: sel_byte = item_i.func;
      tfb_pkg::POS_LEN:  sel_byte = item_i.len;
      tfb_pkg::POS_W0:   sel_byte = item_i.word[31:24];
      tfb_pkg::POS_W1:   sel_byte = item_i.word[23:16];
      tfb_pkg::POS_W2:   sel_byte = item_i.word[15:8];
      tfb_pkg::POS_W3:   sel_byte = item_i.word[7:0];
      tfb_pkg::POS_SUM:  sel_byte = item_i.checksum;
      default:           sel_byte = 8'h00;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    idx_d       = idx_q;
    if (advance) begin
      out_valid_d = item_valid_i;
    end
    if (take) begin
      idx_d = is_final ? 4'd0 : idx_q + 4'd1;
    end
  end

  always_comb begin
    byte_d      = byte_q;
    frame_end_d = frame_end_q;
    last_d      = last_q;
    if (take) begin
      byte_d      = sel_byte;
      frame_end_d = (pos == tfb_pkg::POS_SUM);
      last_d      = is_final;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 4'd0;
    end else begin
      out_valid_q <= out_valid_d;
      idx_q       <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q      <= byte_d;
    frame_end_q <= frame_end_d;
    last_q      <= last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = byte_q;
  assign out_frame_end_o = frame_end_q;
  assign out_last_o      = last_q;

endmodule

`default_nettype wire

FILE: hdl/telemetry_frame_builder.sv
// ----------------------------------------------------------------------------
// telemetry_frame_builder
// Turns 32-bit payload words into a telemetry byte stream with header and
// 8-bit additive checksum.
//
// Input channel: in_valid_i / in_stall_o with in_data_word_i and
// in_frame_words_i; the count is used only on a frame's first word.
// Output channel: out_valid_o / out_stall_i, one byte per transfer, with
// out_frame_end_o on the checksum byte and out_last_o on the final byte
// produced for an input word.
// Config: cfg_we_i writes cfg_data_i into the function code.
// Path: a taken word is held in the word stage's item register, then its bytes load into the output register.
// Throughput: one output byte per cycle while out_stall_i is low; a word
// gives 4 bytes, 5 when it closes a frame, 9 when it opens one and 10 for a
// one-word frame; the byte sequencer and its single output register set it.
// The next word is taken in the cycle its predecessor's final byte is loaded.
// Reset: no frame open, outputs empty, function code 0xF1.
// Stall: the output byte holds while out_stall_i is high and the input
// register fills and then stalls the sender.
// ----------------------------------------------------------------------------
`default_nettype none

module telemetry_frame_builder #(
  parameter int unsigned MAX_WORDS = tfb_pkg::MAX_WORDS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [31:0] in_data_word_i,
  input  wire logic [4:0]  in_frame_words_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       out_byte_o,
  output logic             out_frame_end_o,
  output logic             out_last_o
);

  logic [7:0]     func_code_q;
  logic           item_valid;
  tfb_pkg::item_t item;
  logic           seq_done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      func_code_q <= tfb_pkg::FUNC_RESET;
    end else if (cfg_we_i) begin
      func_code_q <= cfg_data_i;
    end
  end

  tfb_word_stage #(
    .MAX_WORDS(MAX_WORDS)
  ) u_word_stage (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_word_i  (in_data_word_i),
    .frame_words_i(in_frame_words_i),
    .func_i       (func_code_q),
    .done_i       (seq_done),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  tfb_byte_seq u_byte_seq (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_valid_i   (item_valid),
    .item_i         (item),
    .done_o         (seq_done),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .out_frame_end_o(out_frame_end_o),
    .out_last_o     (out_last_o)
  );

  a_end_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_frame_end_o |-> out_last_o)
    else $error("checksum byte not marked last");

  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_last_o |=> out_valid_o)
    else $error("gap inside the bytes of one word");

  a_hold_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    item_valid && !seq_done |-> in_stall_o)
    else $error("word taken while previous word still sending");

  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> item_valid)
    else $error("accepted word not held");

endmodule

`default_nettype wire

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for telemetry_frame_builder. Payload words go in through
// the valid/stall input channel; a scoreboard class predicts each frame's
// header, payload bytes and additive checksum. Every output byte is then
// compared in order against that prediction. Both channels idle at random. The
// function code is rewritten between phases while the block is drained. One
// phase holds off the receiver long enough to back up the input channel.
// ----------------------------------------------------------------------------

module tb_top;

  localparam int unsigned MaxWords    = tfb_pkg::MAX_WORDS_DEF;
  localparam int unsigned HoldCycles  = 300;
  localparam int unsigned TailCycles  = 20;
  localparam int unsigned PhaseCount  = 5;

  class frame_predictor;
    typedef struct {
      bit [7:0] value;
      bit       sum_byte;
      bit       last_byte;
    } stream_byte_t;

    bit [7:0]     func_code;
    bit           frame_open;
    int unsigned  words_left;
    bit [7:0]     running_sum;
    stream_byte_t pending_bytes[$];
    int unsigned  errors;

    function new();
      func_code   = tfb_pkg::FUNC_RESET;
      frame_open  = 1'b0;
      words_left  = 0;
      running_sum = 8'h00;
      errors      = 0;
    endfunction

    function void emit_byte(bit [7:0] value, bit sum_byte);
      stream_byte_t b;
      b.value     = value;
      b.sum_byte  = sum_byte;
      b.last_byte = 1'b0;
      pending_bytes.push_back(b);
      running_sum = running_sum + value;
    endfunction

    function void take_word(bit [31:0] data_word, bit [4:0] frame_words);
      int unsigned  count;
      stream_byte_t tail;
      count = frame_words;
      if (!frame_open) begin
        if (count == 0) count = 1;
        if (count > MaxWords) count = MaxWords;
        running_sum = 8'h00;
        words_left  = count;
        frame_open  = 1'b1;
        emit_byte(tfb_pkg::HDR_SYNC, 1'b0);
        emit_byte(tfb_pkg::HDR_SRC, 1'b0);
        emit_byte(tfb_pkg::HDR_DST, 1'b0);
        emit_byte(func_code, 1'b0);
        emit_byte(8'(count * 4), 1'b0);
      end
      for (int sh = 24; sh >= 0; sh -= 8) begin
        emit_byte(data_word[sh +: 8], 1'b0);
      end
      if (words_left > 0) words_left--;
      if (words_left == 0) begin
        emit_byte(running_sum, 1'b1);
        frame_open  = 1'b0;
        running_sum = 8'h00;
      end
      tail = pending_bytes.pop_back();
      tail.last_byte = 1'b1;
      pending_bytes.push_back(tail);
    endfunction

    function void check_byte(bit [7:0] value, bit sum_byte, bit last_byte);
      stream_byte_t want;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected byte %02h, nothing pending", $time, value);
        errors++;
        return;
      end
      want = pending_bytes.pop_front();
      if (want.value != value) begin
        $display("%0t: out_byte expected %02h actual %02h", $time, want.value, value);
        errors++;
      end
      if (want.sum_byte != sum_byte) begin
        $display("%0t: out_frame_end expected %0b actual %0b", $time,
                 want.sum_byte, sum_byte);
        errors++;
      end
      if (want.last_byte != last_byte) begin
        $display("%0t: out_last expected %0b actual %0b", $time,
                 want.last_byte, last_byte);
        errors++;
      end
    endfunction

    function int unsigned pending();
      return pending_bytes.size();
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [7:0]  cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [31:0] in_data_word_i;
  logic [4:0]  in_frame_words_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [7:0]  out_byte_o;
  logic        out_frame_end_o;
  logic        out_last_o;

  frame_predictor frame_pred;
  bit             tx_calm;
  bit             rx_calm;
  bit             hold_req;

  telemetry_frame_builder u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .in_data_word_i   (in_data_word_i),
    .in_frame_words_i (in_frame_words_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_byte_o       (out_byte_o),
    .out_frame_end_o  (out_frame_end_o),
    .out_last_o       (out_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #20_000_000;
    $display("telemetry_frame_builder regression: fail");
    $finish;
  end

  function automatic int unsigned next_gap();
    int unsigned pick;
    if (tx_calm) return 0;
    pick = $urandom_range(0, 99);
    if (pick < 55) return 0;
    if (pick < 90) return $urandom_range(1, 3);
    if (pick < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  function automatic bit [31:0] random_word();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return 32'h0000_0000;
    if (pick < 10) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  task automatic send_word(input bit [31:0] data, input bit [4:0] count);
    int unsigned gap;
    gap = next_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    in_data_word_i   <= data;
    in_frame_words_i <= count;
    do @(posedge clk_i); while (in_stall_o);
    frame_pred.take_word(data, count);
  endtask

  task automatic send_random_frame(input bit long_frame, output int unsigned sent);
    bit [4:0]    count;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (long_frame) count = (pick < 50) ? 5'd16 : 5'd31;
    else if (pick < 6) count = 5'd0;
    else if (pick < 12) count = 5'($urandom_range(17, 31));
    else if (pick < 20) count = 5'd16;
    else count = 5'($urandom_range(1, 8));
    send_word(random_word(), count);
    sent = 1;
    while (frame_pred.frame_open) begin
      send_word(random_word(), 5'($urandom));
      sent++;
    end
  endtask

  task automatic write_function_code(input bit [7:0] code);
    in_valid_i <= 1'b0;
    while (frame_pred.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_data_i <= code;
    cfg_we_i   <= 1'b1;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    frame_pred.func_code = code;
  endtask

  // receiver pacing: random stalls, calm stretches, one long hold-off
  initial begin
    int unsigned open_len;
    int unsigned stall_len;
    int unsigned pick;
    out_stall_i <= 1'b0;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
      end else if (rx_calm) begin
        out_stall_i <= 1'b0;
        @(posedge clk_i);
      end else begin
        open_len = $urandom_range(1, 24);
        pick     = $urandom_range(0, 99);
        if (pick < 80) stall_len = $urandom_range(1, 3);
        else if (pick < 96) stall_len = $urandom_range(4, 12);
        else stall_len = $urandom_range(20, 60);
        out_stall_i <= 1'b0;
        repeat (open_len) @(posedge clk_i);
        out_stall_i <= 1'b1;
        repeat (stall_len) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_valid_o && !out_stall_i) begin
      frame_pred.check_byte(out_byte_o, out_frame_end_o, out_last_o);
    end
  end

  initial begin
    int unsigned budget;
    int unsigned sent;
    int unsigned n;
    bit [7:0]    code;
    frame_pred = new();
    tx_calm    = 1'b0;
    rx_calm    = 1'b0;
    hold_req   = 1'b0;
    rst_ni     = 1'b0;
    cfg_we_i         <= 1'b0;
    cfg_data_i       <= 8'h00;
    in_valid_i       <= 1'b0;
    in_data_word_i   <= 32'h0;
    in_frame_words_i <= 5'd0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset function code, extreme payloads, zero and saturating counts,
    // counts on later words
    send_word(32'h0000_0000, 5'd1);
    send_word(32'hFFFF_FFFF, 5'd1);
    send_word(32'h1234_5678, 5'd0);
    send_word(32'hAAAA_AAAA, 5'd2);
    send_word(32'h5555_5555, 5'd31);
    send_word(32'h0F0F_0F0F, 5'd3);
    send_word(32'h8000_0001, 5'd0);
    send_word(32'h7FFF_FFFE, 5'd16);
    for (int i = 0; i < 16; i++) begin
      send_word($urandom, (i == 0) ? 5'd31 : 5'($urandom));
    end

    for (int p = 0; p < PhaseCount; p++) begin
      case (p)
        0: code = 8'h00;
        1: code = 8'hFF;
        default: code = 8'($urandom);
      endcase
      write_function_code(code);
      tx_calm = (p == 1) || (p == 2);
      rx_calm = (p == 1);
      if (p == 2) hold_req = 1'b1;
      budget = (p == 2) ? 50 : 60;
      sent   = 0;
      while (sent < budget) begin
        send_random_frame(p == 2, n);
        sent += n;
      end
    end

    in_valid_i <= 1'b0;
    tx_calm = 1'b0;
    rx_calm = 1'b0;
    while (frame_pred.pending() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (frame_pred.errors == 0 && frame_pred.pending() == 0) begin
      $display("telemetry_frame_builder regression: pass");
    end else begin
      $display("telemetry_frame_builder regression: fail");
    end
    $finish;
  end

endmodule

FILE: telemetry_frame_builder.f
hdl/tfb_pkg.sv
hdl/tfb_word_stage.sv
hdl/tfb_byte_seq.sv
hdl/telemetry_frame_builder.sv
bench/tb_top.sv
